[src/request_frame_validator_top_defines.svh]
// Assertion macros for the request frame validator.
`ifndef REQUEST_FRAME_VALIDATOR_TOP_DEFINES_SVH
`define REQUEST_FRAME_VALIDATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Condition that must hold at every edge outside reset.
`define RFV_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Same-cycle implication.
`define RFV_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define RFV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RFV_ASSERT_HOLDS(label, cond, msg)
`define RFV_ASSERT_IMPL(label, ante, cons, msg)
`define RFV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[src/rfv_pkg.sv]
// Types, codes and constants of the request frame validator.
package rfv_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned COUNT_W  = LEN_W + 1;
  localparam int unsigned TAG_W    = 4;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [BYTE_W-1:0]  EXPECTED_VERSION_RST  = 8'd1;
  localparam logic [LEN_W-1:0]   MAX_FIELD_LENGTH_RST  = 16'd1024;
  localparam logic [LEN_W-1:0]   MAX_PAYLOAD_BYTES_RST = 16'd8192;
  localparam logic [COUNT_W-1:0] COUNT_SAT             = 17'h1_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_EXPECTED_VERSION  = 2'd0,
    IDX_MAX_FIELD_LENGTH  = 2'd1,
    IDX_MAX_PAYLOAD_BYTES = 2'd2
  } cfg_index_t;

  typedef enum logic [3:0] {
    PH_VERSION  = 4'd0,
    PH_ID_HI    = 4'd1,
    PH_ID_LO    = 4'd2,
    PH_ID_BODY  = 4'd3,
    PH_RS_HI    = 4'd4,
    PH_RS_LO    = 4'd5,
    PH_RS_BODY  = 4'd6,
    PH_FLAG     = 4'd7,
    PH_TR_HI    = 4'd8,
    PH_TR_LO    = 4'd9,
    PH_TR_BODY  = 4'd10,
    PH_CL_HI    = 4'd11,
    PH_CL_LO    = 4'd12,
    PH_CL_BODY  = 4'd13,
    PH_META_VER = 4'd14,
    PH_DONE     = 4'd15
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_OVERSIZE = 3'd1,
    ST_BADVER   = 3'd2,
    ST_TOOLONG  = 3'd3,
    ST_EMPTYID  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  typedef enum logic [TAG_W-1:0] {
    TAG_VERSION    = 4'd0,
    TAG_ID_LEN     = 4'd1,
    TAG_ID         = 4'd2,
    TAG_REASON_LEN = 4'd3,
    TAG_REASON     = 4'd4,
    TAG_FLAG       = 4'd5,
    TAG_TRACE_LEN  = 4'd6,
    TAG_TRACE      = 4'd7,
    TAG_CALLER_LEN = 4'd8,
    TAG_CALLER     = 4'd9,
    TAG_META_VER   = 4'd10,
    TAG_TRAILING   = 4'd11,
    TAG_DISCARD    = 4'd12
  } tag_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_version;
    logic [LEN_W-1:0]  max_field_length;
    logic [LEN_W-1:0]  max_payload_bytes;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [LEN_W-1:0]   field_remaining;
    logic [BYTE_W-1:0]  length_high_byte;
    logic [COUNT_W-1:0] bytes_seen;
    status_t            first_error;
    logic               metadata_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RST = '{
    phase:            PH_VERSION,
    field_remaining:  '0,
    length_high_byte: '0,
    bytes_seen:       '0,
    first_error:      ST_OK,
    metadata_seen:    1'b0
  };

  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    tag_t              field_tag;
    logic              verdict_ready;
    status_t           status;
    logic              has_metadata;
  } result_t;

  function automatic tag_t phase_tag(input phase_t ph);
    tag_t t;
    case (ph)
      PH_VERSION:  t = TAG_VERSION;
      PH_ID_HI:    t = TAG_ID_LEN;
      PH_ID_LO:    t = TAG_ID_LEN;
      PH_ID_BODY:  t = TAG_ID;
      PH_RS_HI:    t = TAG_REASON_LEN;
      PH_RS_LO:    t = TAG_REASON_LEN;
      PH_RS_BODY:  t = TAG_REASON;
      PH_FLAG:     t = TAG_FLAG;
      PH_TR_HI:    t = TAG_TRACE_LEN;
      PH_TR_LO:    t = TAG_TRACE_LEN;
      PH_TR_BODY:  t = TAG_TRACE;
      PH_CL_HI:    t = TAG_CALLER_LEN;
      PH_CL_LO:    t = TAG_CALLER_LEN;
      PH_CL_BODY:  t = TAG_CALLER;
      PH_META_VER: t = TAG_META_VER;
      default:     t = TAG_TRAILING;
    endcase
    return t;
  endfunction

endpackage

[src/rfv_in_if.sv]
// Request channel carrying payload bytes.
interface rfv_in_if;
  logic                            valid;
  logic                            ready;
  logic [rfv_pkg::BYTE_W-1:0]      payload_byte;
  logic                            end_of_payload;

  modport source (output valid, output payload_byte, output end_of_payload, input ready);
  modport sink   (input valid, input payload_byte, input end_of_payload, output ready);
endinterface

[src/rfv_out_if.sv]
// Result channel carrying tagged bytes and the verdict.
interface rfv_out_if;
  logic                            valid;
  logic                            ready;
  logic [rfv_pkg::BYTE_W-1:0]      byte_value;
  logic [rfv_pkg::TAG_W-1:0]       field_tag;
  logic                            verdict_ready;
  logic [rfv_pkg::STATUS_W-1:0]    status;
  logic                            has_metadata;

  modport source (output valid, output byte_value, output field_tag, output verdict_ready,
                  output status, output has_metadata, input ready);
  modport sink   (input valid, input byte_value, input field_tag, input verdict_ready,
                  input status, input has_metadata, output ready);
endinterface

[src/rfv_cfg_if.sv]
// Register write channel.
interface rfv_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rfv_pkg::CFG_IDX_W-1:0]     index;
  logic [rfv_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rfv_cfg_regs.sv]
// Configuration registers of the validator.
module rfv_cfg_regs (
  input  logic           clk,
  input  logic           rst,
  rfv_cfg_if.sink        cfg,
  output rfv_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_version  <= rfv_pkg::EXPECTED_VERSION_RST;
      regs.max_field_length  <= rfv_pkg::MAX_FIELD_LENGTH_RST;
      regs.max_payload_bytes <= rfv_pkg::MAX_PAYLOAD_BYTES_RST;
    end else if (cfg.valid) begin
      case (rfv_pkg::cfg_index_t'(cfg.index))
        rfv_pkg::IDX_EXPECTED_VERSION: begin
          regs.expected_version <= cfg.data[rfv_pkg::BYTE_W-1:0];
        end
        rfv_pkg::IDX_MAX_FIELD_LENGTH: begin
          regs.max_field_length <= cfg.data[rfv_pkg::LEN_W-1:0];
        end
        rfv_pkg::IDX_MAX_PAYLOAD_BYTES: begin
          regs.max_payload_bytes <= cfg.data[rfv_pkg::LEN_W-1:0];
        end
        default: begin
          // unmapped index: write is dropped
        end
      endcase
    end
  end

endmodule

[src/rfv_step.sv]
// Parse step: next parse state and tagged result for one payload byte.
module rfv_step (
  input  rfv_pkg::parse_state_t        state,
  input  logic [rfv_pkg::BYTE_W-1:0]   payload_byte,
  input  logic                         end_of_payload,
  input  rfv_pkg::cfg_t                regs,
  output rfv_pkg::parse_state_t        state_next,
  output rfv_pkg::result_t             result
);

  rfv_pkg::parse_state_t  upd;
  logic [rfv_pkg::LEN_W-1:0] len;
  logic [rfv_pkg::LEN_W-1:0] rem_dec;
  logic                      len_too_long;
  logic                      len_zero;
  rfv_pkg::phase_t           body_ph;
  rfv_pkg::phase_t           after_ph;
  rfv_pkg::status_t          verdict;

  assign len          = {state.length_high_byte, payload_byte};
  assign len_too_long = len > regs.max_field_length;
  assign len_zero     = len == '0;
  assign rem_dec      = state.field_remaining - 1'b1;

  // where a string goes after its low length byte or its last body byte
  always_comb begin
    case (state.phase)
      rfv_pkg::PH_ID_LO, rfv_pkg::PH_ID_BODY: begin
        body_ph  = rfv_pkg::PH_ID_BODY;
        after_ph = rfv_pkg::PH_RS_HI;
      end
      rfv_pkg::PH_RS_LO, rfv_pkg::PH_RS_BODY: begin
        body_ph  = rfv_pkg::PH_RS_BODY;
        after_ph = rfv_pkg::PH_FLAG;
      end
      rfv_pkg::PH_TR_LO, rfv_pkg::PH_TR_BODY: begin
        body_ph  = rfv_pkg::PH_TR_BODY;
        after_ph = rfv_pkg::PH_CL_HI;
      end
      default: begin
        body_ph  = rfv_pkg::PH_CL_BODY;
        after_ph = rfv_pkg::PH_META_VER;
      end
    endcase
  end

  always_comb begin
    upd = state;
    if (state.bytes_seen != rfv_pkg::COUNT_SAT) begin
      upd.bytes_seen = state.bytes_seen + 1'b1;
    end
    if (state.first_error == rfv_pkg::ST_OK) begin
      case (state.phase)
        rfv_pkg::PH_VERSION: begin
          if (payload_byte != regs.expected_version) upd.first_error = rfv_pkg::ST_BADVER;
          else upd.phase = rfv_pkg::PH_ID_HI;
        end
        rfv_pkg::PH_ID_HI, rfv_pkg::PH_RS_HI, rfv_pkg::PH_TR_HI, rfv_pkg::PH_CL_HI: begin
          upd.length_high_byte = payload_byte;
          upd.phase = rfv_pkg::phase_t'(state.phase + 1'b1);
        end
        rfv_pkg::PH_ID_LO, rfv_pkg::PH_RS_LO, rfv_pkg::PH_TR_LO, rfv_pkg::PH_CL_LO: begin
          if (len_too_long) begin
            upd.first_error = rfv_pkg::ST_TOOLONG;
          end else if (len_zero && state.phase == rfv_pkg::PH_ID_LO) begin
            upd.first_error = rfv_pkg::ST_EMPTYID;
          end else if (len_zero) begin
            upd.phase = after_ph;
          end else begin
            upd.field_remaining = len;
            upd.phase = body_ph;
          end
        end
        rfv_pkg::PH_ID_BODY, rfv_pkg::PH_RS_BODY, rfv_pkg::PH_TR_BODY,
        rfv_pkg::PH_CL_BODY: begin
          upd.field_remaining = rem_dec;
          if (rem_dec == '0) upd.phase = after_ph;
        end
        rfv_pkg::PH_FLAG: begin
          if (payload_byte != '0) begin
            upd.metadata_seen = 1'b1;
            upd.phase = rfv_pkg::PH_TR_HI;
          end else begin
            upd.phase = rfv_pkg::PH_DONE;
          end
        end
        rfv_pkg::PH_META_VER: begin
          upd.phase = rfv_pkg::PH_DONE;
        end
        default: begin
          // trailing bytes after a complete parse
        end
      endcase
    end
  end

  // oversize outranks everything, then the recorded error, then truncation
  always_comb begin
    if (upd.bytes_seen > {1'b0, regs.max_payload_bytes}) verdict = rfv_pkg::ST_OVERSIZE;
    else if (upd.first_error != rfv_pkg::ST_OK) verdict = upd.first_error;
    else if (upd.phase != rfv_pkg::PH_DONE) verdict = rfv_pkg::ST_TRUNC;
    else verdict = rfv_pkg::ST_OK;
  end

  always_comb begin
    result.byte_value    = payload_byte;
    result.field_tag     = (state.first_error != rfv_pkg::ST_OK) ? rfv_pkg::TAG_DISCARD
                                                             : rfv_pkg::phase_tag(state.phase);
    result.verdict_ready = end_of_payload;
    result.status        = end_of_payload ? verdict : rfv_pkg::ST_OK;
    result.has_metadata  = upd.metadata_seen;
    state_next           = end_of_payload ? rfv_pkg::STATE_RST : upd;
  end

endmodule

[src/request_frame_validator_top.sv]
// Request frame validator: tags each payload byte and gives a verdict on the last one.
//
// Channels: req takes one payload byte per request with an end_of_payload mark;
// rsp returns one result per request: the byte, its field tag and the metadata
// flag, and on the final byte verdict_ready with the status. cfg writes the
// expected version, the largest string length and the largest payload size;
// writes are taken at any time but must only be issued while the block is idle.
//
// Path: a request passes the input register, then the result register that also
// updates the parse state. Throughput: one request per cycle while rsp is taken;
// the parse state update between the two registers includes a 16-bit length
// compare and a 17-bit count compare.
//
// Reset: all parse state clears and the registers return to version 1, max
// length 1024 and max payload 8192. No clearing pass is needed.
// Stall: when rsp is not taken, the result holds, one more request waits in the
// input register, and req.ready drops until the result register frees.
`include "request_frame_validator_top_defines.svh"

module request_frame_validator_top (
  input  logic       clk,
  input  logic       rst,
  rfv_in_if.sink     req,
  rfv_out_if.source  rsp,
  rfv_cfg_if.sink    cfg
);

  rfv_pkg::cfg_t              regs;
  rfv_pkg::parse_state_t      state;
  rfv_pkg::parse_state_t      state_next;
  rfv_pkg::result_t           result;
  rfv_pkg::result_t           out_data;

  logic                       in_valid;
  logic [rfv_pkg::BYTE_W-1:0] in_byte;
  logic                       in_last;
  logic                       out_valid;
  logic                       advance;
  logic                       step_fire;

  assign advance   = !out_valid || rsp.ready;
  assign step_fire = in_valid && advance;
  assign req.ready = !in_valid || advance;

  rfv_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rfv_step u_step (
    .state          (state),
    .payload_byte   (in_byte),
    .end_of_payload (in_last),
    .regs           (regs),
    .state_next     (state_next),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_byte <= req.payload_byte;
      in_last <= req.end_of_payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      state     <= rfv_pkg::STATE_RST;
    end else begin
      if (advance) out_valid <= in_valid;
      if (step_fire) state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      out_data <= result;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.byte_value    = out_data.byte_value;
  assign rsp.field_tag     = out_data.field_tag;
  assign rsp.verdict_ready = out_data.verdict_ready;
  assign rsp.status        = out_data.status;
  assign rsp.has_metadata  = out_data.has_metadata;

  // a status only rides on the final byte of a payload
  `RFV_ASSERT_IMPL(a_status_on_verdict, out_valid && !out_data.verdict_ready, out_data.status == rfv_pkg::ST_OK, "status without verdict")
  // parse state is back at reset after the final byte
  `RFV_ASSERT_NEXT(a_clear_after_last, step_fire && in_last, state.phase == rfv_pkg::PH_VERSION && state.bytes_seen == '0 && state.first_error == rfv_pkg::ST_OK, "state not cleared after final byte")
  // a waiting request is not dropped while the result register is full
  `RFV_ASSERT_NEXT(a_input_held, in_valid && !advance, in_valid && $stable(in_byte) && $stable(in_last), "pending request lost during stall")
  // the count moves only when a byte is consumed
  `RFV_ASSERT_NEXT(a_count_steady, !step_fire, $stable(state.bytes_seen), "byte count moved without a request")

endmodule
